// ===== src/rrts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared codes, reset constants and the ready ring control struct for the
// round-robin thread scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

	localparam int NUM_THREADS_DEF = 16;
	localparam int IDLE_SLOT_DEF   = 1;

	// request kinds
	localparam logic [2:0] REQ_CREATE  = 3'd0;
	localparam logic [2:0] REQ_PREEMPT = 3'd1;
	localparam logic [2:0] REQ_BLOCK   = 3'd2;
	localparam logic [2:0] REQ_UNBLOCK = 3'd3;
	localparam logic [2:0] REQ_YIELD   = 3'd4;

	// block kinds
	localparam logic [1:0] KIND_BLOCKED = 2'd0;
	localparam logic [1:0] KIND_WAITING = 2'd1;
	localparam logic [1:0] KIND_HANGING = 2'd2;

	// slot states
	localparam logic [2:0] ST_UNUSED  = 3'd0;
	localparam logic [2:0] ST_RUNNING = 3'd1;
	localparam logic [2:0] ST_READY   = 3'd2;
	localparam logic [2:0] ST_BLOCKED = 3'd3;
	localparam logic [2:0] ST_WAITING = 3'd4;
	localparam logic [2:0] ST_HANGING = 3'd5;

	// reset priorities (a slot's slice always equals its priority)
	localparam logic [7:0] BOOT_PRIO = 8'd31;
	localparam logic [7:0] IDLE_PRIO = 8'd10;

	localparam logic [31:0] PID_RESET = 32'd2;

	typedef struct packed {
		logic push_tail;
		logic push_head;
		logic pop;
	} ring_op_t;

endpackage

// ===== src/round_robin_thread_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler
// A request is taken into the request register; done is then registered
// from it. Throughput: one request per cycle; busy never rises. The running
// slot, its slice and the ready queue depth update with done.
// Reset: slot 0 running, idle slot alone in the ready queue, next id 3.
// The receiver cannot stall; each result shows for exactly one cycle.
// ----------------------------------------------------------------------------
module round_robin_thread_scheduler #(
	parameter int NUM_THREADS = rrts_pkg::NUM_THREADS_DEF,
	parameter int IDLE_SLOT   = rrts_pkg::IDLE_SLOT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  req_type,
	input  logic [3:0]  thread_id,
	input  logic [1:0]  block_kind,
	input  logic [7:0]  priority_req,
	output logic        done,
	output logic [3:0]  running_id,
	output logic        switched,
	output logic [31:0] new_pid,
	output logic [7:0]  running_slice,
	output logic [4:0]  ready_count,
	output logic        error
);

	localparam int SLOT_W   = $clog2(NUM_THREADS);
	localparam int IDLE_MOD = IDLE_SLOT % NUM_THREADS;
	localparam int IDLE_IDX = (IDLE_MOD == 0) ? 1 : IDLE_MOD;

	// request register
	logic              valid_s1;
	logic [2:0]        req_s1;
	logic [3:0]        tid_s1;
	logic [1:0]        kind_s1;
	logic [7:0]        prio_s1;

	// scheduler state
	logic [2:0]        status_q [NUM_THREADS];
	logic [7:0]        prio_q   [NUM_THREADS];
	logic [SLOT_W-1:0] cur_q;
	logic [7:0]        cur_prio_q;
	logic [31:0]       pid_q;

	// result register
	logic              done_q;
	logic              switched_q;
	logic [31:0]       new_pid_q;
	logic              error_q;

	rrts_pkg::ring_op_t ring_op;
	logic [SLOT_W-1:0] push_slot;
	logic [7:0]        push_prio;
	logic [SLOT_W-1:0] head_slot;
	logic [7:0]        head_prio;
	logic [SLOT_W:0]   ring_count;

	logic              tid_ok;
	logic [SLOT_W-1:0] tid_idx;
	logic [2:0]        tid_status;
	logic              tid_parked;
	logic              err;
	logic              do_create;
	logic              do_pick;
	logic [SLOT_W-1:0] next_slot;
	logic [7:0]        next_prio;
	logic              wa_en;
	logic [SLOT_W-1:0] wa_idx;
	logic [2:0]        wa_val;

	function automatic logic block_kind_bad(input logic [1:0] k);
		return (k != rrts_pkg::KIND_BLOCKED) && (k != rrts_pkg::KIND_WAITING) &&
			(k != rrts_pkg::KIND_HANGING);
	endfunction

	assign tid_ok     = (32'(tid_s1) < 32'(NUM_THREADS));
	assign tid_idx    = SLOT_W'(tid_s1);
	assign tid_status = status_q[tid_idx];
	assign tid_parked = (tid_status == rrts_pkg::ST_BLOCKED) ||
		(tid_status == rrts_pkg::ST_WAITING) || (tid_status == rrts_pkg::ST_HANGING);

	always_comb begin
		err        = 1'b0;
		do_create  = 1'b0;
		do_pick    = 1'b0;
		ring_op    = '0;
		push_slot  = cur_q;
		push_prio  = cur_prio_q;
		wa_en      = 1'b0;
		wa_idx     = cur_q;
		wa_val     = rrts_pkg::ST_READY;
		case (req_s1)
			rrts_pkg::REQ_CREATE: begin
				if (!tid_ok || tid_status != rrts_pkg::ST_UNUSED) begin
					err = 1'b1;
				end else begin
					do_create         = 1'b1;
					ring_op.push_tail = 1'b1;
					push_slot         = tid_idx;
					push_prio         = prio_s1;
					wa_en             = 1'b1;
					wa_idx            = tid_idx;
				end
			end
			rrts_pkg::REQ_PREEMPT, rrts_pkg::REQ_YIELD: begin
				// slice always equals priority, so the reload on preempt is implicit
				ring_op.push_tail = 1'b1;
				ring_op.pop       = 1'b1;
				do_pick           = 1'b1;
				wa_en             = 1'b1;
			end
			rrts_pkg::REQ_BLOCK: begin
				if (block_kind_bad(kind_s1)) begin
					err = 1'b1;
				end else begin
					ring_op.pop = 1'b1;
					do_pick     = 1'b1;
					wa_en       = 1'b1;
					wa_val      = rrts_pkg::ST_BLOCKED + 3'(kind_s1);
				end
			end
			rrts_pkg::REQ_UNBLOCK: begin
				if (!tid_ok || !tid_parked) begin
					err = 1'b1;
				end else begin
					ring_op.push_head = 1'b1;
					push_slot         = tid_idx;
					push_prio         = prio_q[tid_idx];
					wa_en             = 1'b1;
					wa_idx            = tid_idx;
				end
			end
			default: err = 1'b1;
		endcase
		if (!valid_s1) begin
			err        = 1'b0;
			do_create  = 1'b0;
			do_pick    = 1'b0;
			ring_op    = '0;
			wa_en      = 1'b0;
		end
	end

	// pick the new running slot: idle on an empty ring for block,
	// the slot just re-queued on an empty ring for preempt and yield
	always_comb begin
		if (ring_count != '0) begin
			next_slot = head_slot;
			next_prio = head_prio;
		end else if (ring_op.push_tail) begin
			next_slot = cur_q;
			next_prio = cur_prio_q;
		end else begin
			next_slot = SLOT_W'(IDLE_IDX);
			next_prio = rrts_pkg::IDLE_PRIO;
		end
	end

	rrts_ring #(
		.NUM_THREADS (NUM_THREADS),
		.IDLE_IDX    (IDLE_IDX),
		.SLOT_W      (SLOT_W)
	) u_ring (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (ring_op),
		.push_slot (push_slot),
		.push_prio (push_prio),
		.head_slot (head_slot),
		.head_prio (head_prio),
		.count     (ring_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			req_s1  <= req_type;
			tid_s1  <= thread_id;
			kind_s1 <= block_kind;
			prio_s1 <= priority_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_THREADS; i++) begin
				if (i == 0) begin
					status_q[i] <= rrts_pkg::ST_RUNNING;
					prio_q[i]   <= rrts_pkg::BOOT_PRIO;
				end else if (i == IDLE_IDX) begin
					status_q[i] <= rrts_pkg::ST_READY;
					prio_q[i]   <= rrts_pkg::IDLE_PRIO;
				end else begin
					status_q[i] <= rrts_pkg::ST_UNUSED;
					prio_q[i]   <= '0;
				end
			end
			cur_q      <= '0;
			cur_prio_q <= rrts_pkg::BOOT_PRIO;
			pid_q      <= rrts_pkg::PID_RESET;
		end else begin
			// the new running slot overrides the write to the old one
			if (wa_en && !(do_pick && (next_slot == wa_idx))) begin
				status_q[wa_idx] <= wa_val;
			end
			if (do_pick) begin
				status_q[next_slot] <= rrts_pkg::ST_RUNNING;
				cur_q               <= next_slot;
				cur_prio_q          <= next_prio;
			end
			if (do_create) begin
				prio_q[tid_idx] <= prio_s1;
				pid_q           <= pid_q + 32'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		error_q    <= err;
		switched_q <= do_pick && (next_slot != cur_q);
		new_pid_q  <= do_create ? pid_q + 32'd1 : 32'd0;
	end

	assign busy          = 1'b0;
	assign done          = done_q;
	assign switched      = switched_q;
	assign new_pid       = new_pid_q;
	assign error         = error_q;
	assign running_id    = 4'(cur_q);
	assign running_slice = cur_prio_q;
	assign ready_count   = 5'(ring_count);

endmodule

// ===== src/rrts_ring.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_ring
// Circular ready queue of slot numbers with their priorities. Supports push
// at tail, push at head and pop of the head; a push at tail and a pop can be done together.
// ----------------------------------------------------------------------------
module rrts_ring #(
	parameter int NUM_THREADS = rrts_pkg::NUM_THREADS_DEF,
	parameter int IDLE_IDX    = 1,
	parameter int SLOT_W      = $clog2(NUM_THREADS)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rrts_pkg::ring_op_t   op,
	input  logic [SLOT_W-1:0]    push_slot,
	input  logic [7:0]           push_prio,
	output logic [SLOT_W-1:0]    head_slot,
	output logic [7:0]           head_prio,
	output logic [SLOT_W:0]      count
);

	localparam int CW = SLOT_W + 1;

	logic [SLOT_W-1:0] ring_slot_q [NUM_THREADS];
	logic [7:0]        ring_prio_q [NUM_THREADS];
	logic [SLOT_W-1:0] head_q;
	logic [CW-1:0]     count_q;

	logic [CW-1:0]     tail_sum;
	logic [SLOT_W-1:0] tail_idx;
	logic [SLOT_W-1:0] head_inc;
	logic [SLOT_W-1:0] head_dec;
	logic              full;
	logic              empty;

	logic              wr_en;
	logic [SLOT_W-1:0] wr_idx;
	logic [SLOT_W-1:0] head_nxt;
	logic [CW-1:0]     count_nxt;

	assign tail_sum = CW'(head_q) + count_q;
	assign tail_idx = (tail_sum >= CW'(NUM_THREADS)) ?
		SLOT_W'(tail_sum - CW'(NUM_THREADS)) : SLOT_W'(tail_sum);
	assign head_inc = (head_q == SLOT_W'(NUM_THREADS - 1)) ? '0 : head_q + 1'b1;
	assign head_dec = (head_q == '0) ? SLOT_W'(NUM_THREADS - 1) : head_q - 1'b1;
	assign full     = (count_q == CW'(NUM_THREADS));
	assign empty    = (count_q == '0);

	assign head_slot = ring_slot_q[head_q];
	assign head_prio = ring_prio_q[head_q];
	assign count     = count_q;

	always_comb begin
		wr_en     = 1'b0;
		wr_idx    = tail_idx;
		head_nxt  = head_q;
		count_nxt = count_q;
		if (op.push_tail && op.pop) begin
			// on an empty ring the pushed entry lands at head and pops straight out
			if (!full) begin
				wr_en    = 1'b1;
				head_nxt = head_inc;
			end else begin
				head_nxt  = head_inc;
				count_nxt = count_q - 1'b1;
			end
		end else if (op.pop) begin
			// empty pop: the ring is left as is; the scheduler picks the idle slot
			if (!empty) begin
				head_nxt  = head_inc;
				count_nxt = count_q - 1'b1;
			end
		end else if (op.push_tail) begin
			if (!full) begin
				wr_en     = 1'b1;
				count_nxt = count_q + 1'b1;
			end
		end else if (op.push_head) begin
			if (!full) begin
				wr_en     = 1'b1;
				wr_idx    = head_dec;
				head_nxt  = head_dec;
				count_nxt = count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_THREADS; i++) begin
				ring_slot_q[i] <= (i == 0) ? SLOT_W'(IDLE_IDX) : '0;
				ring_prio_q[i] <= (i == 0) ? rrts_pkg::IDLE_PRIO : '0;
			end
			head_q         <= '0;
			count_q        <= CW'(1);
		end else begin
			if (wr_en) begin
				ring_slot_q[wr_idx] <= push_slot;
				ring_prio_q[wr_idx] <= push_prio;
			end
			head_q  <= head_nxt;
			count_q <= count_nxt;
		end
	end

endmodule
